// ===== rtl/mmn_pkg.sv =====
`default_nettype none

package mmn_pkg;

  // widths of the result pixel and the item opcode
  localparam int PIXEL_BITS  = 8;
  localparam int OPCODE_BITS = 2;

  // default sample width, handed down to the top level and its sub-blocks
  localparam int SAMPLE_BITS_DEF = 16;

  // short queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one quotient bit per divider step
  localparam int DIV_STEPS = PIXEL_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = {PIXEL_BITS{1'b1}};

  // item opcodes; the fourth code is dropped at the front
  typedef enum logic [OPCODE_BITS-1:0] {
    OP_SEED    = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_CONVERT = 2'd2
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/mmn_front.sv =====
`default_nettype none

module mmn_front #(
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [mmn_pkg::OPCODE_BITS-1:0] in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                                 fq_push,
  input  wire logic                            fq_full,
  output mmn_pkg::op_t                         fq_op,
  output logic signed [SAMPLE_BITS-1:0]        fq_sample
);
  import mmn_pkg::*;

  logic                          fr_valid_r, fr_valid_nxt;
  op_t                           fr_op_r;
  logic signed [SAMPLE_BITS-1:0] fr_sample_r;
  logic                          accept;
  logic                          op_used;

  // classify: the unused opcode is taken and dropped
  always_comb begin
    unique case (in_opcode)
      OP_SEED, OP_OBSERVE, OP_CONVERT: op_used = 1'b1;
      default:                         op_used = 1'b0;
    endcase
  end

  assign fq_push   = fr_valid_r && !fq_full;
  assign in_full   = fr_valid_r && fq_full;
  assign accept    = in_push && !in_full;
  assign fq_op     = fr_op_r;
  assign fq_sample = fr_sample_r;

  // stage valid
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = op_used;
    end else if (fq_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept && op_used) begin
      fr_op_r     <= op_t'(in_opcode);
      fr_sample_r <= in_sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmn_queue.sv =====
`default_nettype none

module mmn_queue #(
  parameter int WIDTH = mmn_pkg::SAMPLE_BITS_DEF + mmn_pkg::OPCODE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data
);
  import mmn_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entry_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_data = entry_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmn_back.sv =====
`default_nettype none

module mmn_back #(
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           bq_valid,
  output logic                                bq_pop,
  input  wire mmn_pkg::op_t                   bq_op,
  input  wire logic signed [SAMPLE_BITS-1:0]  bq_sample,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [mmn_pkg::PIXEL_BITS-1:0]      out_pixel,
  output logic                                out_degenerate
);
  import mmn_pkg::*;

  // remainder holds diff * 255, which needs PIXEL_BITS more bits
  localparam int RW = SAMPLE_BITS + PIXEL_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS:0]   diff_r;
  logic [SAMPLE_BITS-1:0]        span_r;
  logic                          degen_r;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [RW-1:0]                 div_r, div_nxt;
  logic [PIXEL_BITS-1:0]         quo_r, quo_nxt;
  logic [CNT_BITS-1:0]           cnt_r, cnt_nxt;
  logic [PIXEL_BITS-1:0]         res_pix_r, res_pix_nxt;
  logic                          res_degen_r, res_degen_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [PIXEL_BITS-1:0]         out_pixel_r;
  logic                          out_degen_r;
  logic                          out_load;
  logic [SAMPLE_BITS-1:0]        diff_mag;
  logic                          diff_pos;
  logic                          rem_ge;

  assign diff_mag = diff_r[SAMPLE_BITS-1:0];
  assign diff_pos = !diff_r[SAMPLE_BITS] && (diff_r != '0);
  assign rem_ge   = (rem_r >= div_r);
  assign bq_pop   = (state_r == ST_IDLE) && bq_valid;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_pop);

  // sequencer: range update, set-up, restoring divide, hand-over
  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_pix_nxt   = res_pix_r;
    res_degen_nxt = res_degen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (bq_valid) begin
          unique case (bq_op)
            OP_SEED: begin
              min_nxt = bq_sample;
              max_nxt = bq_sample;
            end
            OP_OBSERVE: begin
              if (bq_sample < min_r) begin
                min_nxt = bq_sample;
              end
              if (bq_sample > max_r) begin
                max_nxt = bq_sample;
              end
            end
            OP_CONVERT: begin
              state_nxt = ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        res_degen_nxt = degen_r;
        res_pix_nxt   = '0;
        state_nxt     = ST_OUT;
        if (!degen_r && diff_pos) begin
          if (diff_mag >= span_r) begin
            res_pix_nxt = PIXEL_MAX;
          end else begin
            // diff * 255 as (diff << 8) - diff
            rem_nxt   = {diff_mag, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, diff_mag};
            div_nxt   = {1'b0, span_r, {(PIXEL_BITS-1){1'b0}}};
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? (rem_r - div_r) : rem_r;
        div_nxt = div_r >> 1;
        quo_nxt = {quo_r[PIXEL_BITS-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_STEPS - 1)) begin
          res_pix_nxt = quo_nxt;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_r   <= '0;
      max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // convert operands, taken from the queue head with the current range
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      diff_r  <= {bq_sample[SAMPLE_BITS-1], bq_sample} - {min_r[SAMPLE_BITS-1], min_r};
      span_r  <= max_r - min_r;
      degen_r <= !(max_r > min_r);
    end
  end

  // divider datapath and pending result
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    res_pix_r   <= res_pix_nxt;
    res_degen_r <= res_degen_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= res_pix_r;
      out_degen_r <= res_degen_r;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_degenerate = out_degen_r;

`ifndef SYNTHESIS
  // range never inverts
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("range minimum above maximum");

  // queue is drained only between items
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bq_pop |-> (state_r == ST_IDLE))
    else $error("queue popped while busy");

  // divider ends after its last step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == CNT_BITS'(DIV_STEPS - 1)) |=> (state_r == ST_OUT))
    else $error("divider overran");

  // degenerate result carries a zero pixel
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |-> (out_pixel_r == '0))
    else $error("degenerate result with nonzero pixel");
`endif

endmodule

`default_nettype wire

// ===== rtl/minmax_normalize_to_byte_top.sv =====
`default_nettype none
// results: seed and observe items give no result; a convert item reaches the result ports
//   through the front stage, queue, set-up, 8 divide steps and output register, or without
//   the divide steps when the range is flat or the sample lies at or outside its bounds
// rate: one seed or observe item per cycle while the back end is idle; a convert item holds
//   the back end through set-up, the restoring divide at one quotient bit a cycle, and hand-over
// reset: synchronous active-low rst_n empties the front stage, queue and output register
//   and clears the range to 0..0

module minmax_normalize_to_byte_top #(
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [mmn_pkg::OPCODE_BITS-1:0] in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [mmn_pkg::PIXEL_BITS-1:0]       out_pixel,
  output logic                                 out_degenerate
);
  import mmn_pkg::*;

  localparam int QW = SAMPLE_BITS + OPCODE_BITS;

  logic                          fq_push;
  logic                          fq_full;
  op_t                           fq_op;
  logic signed [SAMPLE_BITS-1:0] fq_sample;
  logic                          bq_valid;
  logic                          bq_pop;
  logic [QW-1:0]                 bq_data;
  op_t                           bq_op;
  logic signed [SAMPLE_BITS-1:0] bq_sample;

  // front: accept and classify
  mmn_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_sample (in_sample),
    .fq_push   (fq_push),
    .fq_full   (fq_full),
    .fq_op     (fq_op),
    .fq_sample (fq_sample)
  );

  // short queue between front and back
  mmn_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data ({fq_op, fq_sample}),
    .valid   (bq_valid),
    .pop     (bq_pop),
    .rd_data (bq_data)
  );

  assign bq_op     = op_t'(bq_data[QW-1:SAMPLE_BITS]);
  assign bq_sample = bq_data[SAMPLE_BITS-1:0];

  // back: range tracking and conversion
  mmn_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .bq_valid       (bq_valid),
    .bq_pop         (bq_pop),
    .bq_op          (bq_op),
    .bq_sample      (bq_sample),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel      (out_pixel),
    .out_degenerate (out_degenerate)
  );

endmodule

`default_nettype wire
